@@ rtl/eapol_handshake_tracker_core_macros.svh @@
// Assertion macros for the EAPOL handshake tracker core.
// Used by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef EAPOL_HANDSHAKE_TRACKER_CORE_MACROS_SVH
`define EAPOL_HANDSHAKE_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EHT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eht check failed");

// Next-cycle implication, disabled during reset.
`define EHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eht check failed");

`endif

@@ rtl/eht_pkg.sv @@
// Shared types, constants and the key-info classifier of the EAPOL handshake tracker.
// No dependencies.
package eht_pkg;

  localparam int unsigned FRAME_MAX_DEF = 256;

  localparam int unsigned MIN_LEN     = 99;
  localparam logic [7:0]  KEY_TYPE    = 8'd3;
  localparam int unsigned POS_TYPE    = 1;
  localparam int unsigned POS_INFO_HI = 5;
  localparam int unsigned POS_INFO_LO = 6;
  localparam int unsigned NONCE_OFS   = 17;
  localparam int unsigned NONCE_LEN   = 32;
  localparam int unsigned MIC_OFS     = 81;
  localparam int unsigned MIC_LEN     = 16;

  localparam logic [15:0] INFO_PAIRWISE = 16'h0008;
  localparam logic [15:0] INFO_MIC      = 16'h0100;
  localparam logic [15:0] INFO_ACK      = 16'h0080;
  localparam logic [15:0] INFO_INSTALL  = 16'h0040;

  localparam logic [2:0] MSG_NONE = 3'd0;
  localparam logic [2:0] MSG_1    = 3'd1;
  localparam logic [2:0] MSG_2    = 3'd2;
  localparam logic [2:0] MSG_3    = 3'd3;
  localparam logic [2:0] MSG_4    = 3'd4;

  localparam logic [1:0] REGION_ANONCE = 2'd0;
  localparam logic [1:0] REGION_SNONCE = 2'd1;
  localparam logic [1:0] REGION_MIC    = 2'd2;
  localparam logic [1:0] REGION_FRAME  = 2'd3;

  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [47:0] src_addr;
    logic [47:0] dst_addr;
    logic [1:0]  read_region;
    logic [7:0]  read_offset;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  msg_code;
    logic [3:0]  progress_mask;
    logic        handshake_complete;
    logic [47:0] ap_addr;
    logic [47:0] client_addr;
    logic [8:0]  stored_len;
    logic [7:0]  read_data;
  } out_t;

  // Capture strobes for one frame beat.
  typedef struct packed {
    logic       bank_we;
    logic       nonce_we;
    logic [4:0] nonce_idx;
    logic       mic_we;
    logic [3:0] mic_idx;
    logic [7:0] data;
  } cap_t;

  // Commit requests raised at the end of an accepted frame.
  typedef struct packed {
    logic anonce;
    logic snonce_mic;
    logic frame;
  } commit_t;

  // Handshake status as seen after the current beat.
  typedef struct packed {
    logic [3:0]  seen;
    logic        done;
    logic [47:0] ap;
    logic [47:0] client;
    logic [8:0]  stored_len;
  } status_t;

  function automatic logic [2:0] classify(input logic [15:0] info, input logic seen_m3);
    logic ack;
    logic mic;
    logic ins;
    logic [2:0] msg;
    ack = (info & INFO_ACK) != 16'h0;
    mic = (info & INFO_MIC) != 16'h0;
    ins = (info & INFO_INSTALL) != 16'h0;
    msg = MSG_NONE;
    if ((info & INFO_PAIRWISE) != 16'h0) begin
      if (ack && !mic && !ins) begin
        msg = MSG_1;
      end else if (!ack && mic && !ins) begin
        msg = seen_m3 ? MSG_4 : MSG_2;
      end else if (ack && mic && ins) begin
        msg = MSG_3;
      end
    end
    return msg;
  endfunction

endpackage

@@ rtl/eht_frame_ctl.sv @@
// Frame byte counter, header parse, message classification and handshake state.
// Depends on eht_pkg.
module eht_frame_ctl import eht_pkg::*; #(
  parameter int unsigned FRAME_MAX = FRAME_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_en,
  input  logic [7:0]                    data_byte,
  input  logic                          last_byte,
  input  logic [47:0]                   src_addr,
  input  logic [47:0]                   dst_addr,
  output cap_t                          cap,
  output logic [$clog2(FRAME_MAX)-1:0]  bank_pos,
  output commit_t                       commit,
  output logic [$clog2(FRAME_MAX+2)-1:0] saved_len,
  output logic [2:0]                    msg_code,
  output status_t                       status
);

  localparam int unsigned CW = $clog2(FRAME_MAX + 2);
  localparam int unsigned PW = $clog2(FRAME_MAX);

  logic [CW-1:0] byte_count_r, byte_count_nxt;
  logic [47:0]   frame_src_r, frame_dst_r;
  logic          type_key_r;
  logic [15:0]   key_info_r;
  logic [47:0]   learned_ap_r, learned_ap_nxt;
  logic [47:0]   learned_client_r, learned_client_nxt;
  logic [3:0]    seen_r, seen_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] saved_len_r, saved_len_nxt;

  logic [CW-1:0] pos, len;
  logic [CW-1:0] nonce_rel, mic_rel;
  logic [CW+8:0] len_w;
  logic          frame_end, known, from_ap, ok;
  logic [2:0]    raw_msg, msg;
  logic [47:0]   ap_eff;

  assign pos       = byte_count_r;
  assign len       = (pos < CW'(FRAME_MAX + 1)) ? pos + CW'(1) : CW'(FRAME_MAX + 1);
  assign nonce_rel = pos - CW'(NONCE_OFS);
  assign mic_rel   = pos - CW'(MIC_OFS);
  assign frame_end = byte_en && last_byte;

  always_comb begin
    cap.bank_we   = byte_en && (pos < CW'(FRAME_MAX));
    cap.nonce_we  = byte_en && (pos >= CW'(NONCE_OFS)) && (pos < CW'(NONCE_OFS + NONCE_LEN));
    cap.nonce_idx = nonce_rel[4:0];
    cap.mic_we    = byte_en && (pos >= CW'(MIC_OFS)) && (pos < CW'(MIC_OFS + MIC_LEN));
    cap.mic_idx   = mic_rel[3:0];
    cap.data      = data_byte;
  end
  assign bank_pos = pos[PW-1:0];

  // End-of-frame verdict; header fields are all registered by now.
  assign known   = seen_r[0];
  assign ap_eff  = known ? learned_ap_r : frame_src_r;
  assign from_ap = (frame_src_r == ap_eff);
  assign raw_msg = ((len >= CW'(MIN_LEN)) && type_key_r) ? classify(key_info_r, seen_r[2])
                                                         : MSG_NONE;

  always_comb begin
    case (raw_msg) inside
      MSG_1:        ok = from_ap;
      MSG_3:        ok = known && from_ap;
      MSG_2, MSG_4: ok = known && !from_ap;
      default:      ok = 1'b0;
    endcase
  end

  assign msg = (frame_end && ok) ? raw_msg : MSG_NONE;

  always_comb begin
    seen_nxt           = seen_r;
    done_nxt           = done_r;
    learned_ap_nxt     = learned_ap_r;
    learned_client_nxt = learned_client_r;
    saved_len_nxt      = saved_len_r;
    commit             = '0;
    unique case (msg)
      MSG_1: begin
        seen_nxt[0]   = 1'b1;
        commit.anonce = 1'b1;
        if (!known) begin
          learned_ap_nxt     = frame_src_r;
          learned_client_nxt = frame_dst_r;
        end
      end
      MSG_2: begin
        seen_nxt[1]       = 1'b1;
        commit.snonce_mic = 1'b1;
        if (len <= CW'(FRAME_MAX)) begin
          commit.frame  = 1'b1;
          saved_len_nxt = len;
        end
      end
      MSG_3:   seen_nxt[2] = 1'b1;
      MSG_4:   seen_nxt[3] = 1'b1;
      default: ;
    endcase
    if (seen_nxt == 4'hF) begin
      done_nxt = 1'b1;
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    if (byte_en) begin
      byte_count_nxt = last_byte ? '0 : len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r     <= '0;
      frame_src_r      <= '0;
      frame_dst_r      <= '0;
      type_key_r       <= 1'b0;
      key_info_r       <= '0;
      learned_ap_r     <= '0;
      learned_client_r <= '0;
      seen_r           <= '0;
      done_r           <= 1'b0;
      saved_len_r      <= '0;
    end else begin
      byte_count_r     <= byte_count_nxt;
      learned_ap_r     <= learned_ap_nxt;
      learned_client_r <= learned_client_nxt;
      seen_r           <= seen_nxt;
      done_r           <= done_nxt;
      saved_len_r      <= saved_len_nxt;
      if (byte_en) begin
        if (pos == '0) begin
          frame_src_r <= src_addr;
          frame_dst_r <= dst_addr;
        end
        if (pos == CW'(POS_TYPE)) begin
          type_key_r <= (data_byte == KEY_TYPE);
        end
        if (pos == CW'(POS_INFO_HI)) begin
          key_info_r[15:8] <= data_byte;
        end
        if (pos == CW'(POS_INFO_LO)) begin
          key_info_r[7:0] <= data_byte;
        end
      end
    end
  end

  assign len_w     = {9'd0, saved_len_nxt};
  assign saved_len = saved_len_r;
  assign msg_code  = msg;

  always_comb begin
    status.seen       = seen_nxt;
    status.done       = done_nxt;
    status.ap         = learned_ap_nxt;
    status.client     = learned_client_nxt;
    status.stored_len = len_w[8:0];
  end

endmodule

@@ rtl/eht_store.sv @@
// Nonce/MIC memory and frame capture memory with slot rotation and registered read.
// Depends on eht_pkg.
module eht_store import eht_pkg::*; #(
  parameter int unsigned FRAME_MAX = FRAME_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cap_t                           cap,
  input  logic [$clog2(FRAME_MAX)-1:0]   bank_pos,
  input  commit_t                        commit,
  input  logic                           rd_en,
  input  logic [1:0]                     rd_region,
  input  logic [7:0]                     rd_offset,
  input  logic [$clog2(FRAME_MAX+2)-1:0] saved_len,
  output logic [7:0]                     rd_data
);

  localparam int unsigned CW = $clog2(FRAME_MAX + 2);
  localparam int unsigned PW = $clog2(FRAME_MAX);

  // Slot 3 of the nonce memory holds the MIC halves.
  localparam logic [1:0] MIC_SLOT = 2'd3;

  // Nonce memory: four 32-byte slots. Slots 0-2 rotate among anonce, snonce and
  // staging; slot 3 holds two 16-byte MIC halves, one live and one staging.
  logic [7:0] nonce_mem [0:127];
  // Frame memory: two banks, one committed and one capturing.
  logic [7:0] bank_mem [0:(2 << PW)-1];

  logic [1:0] anonce_slot_r, snonce_slot_r, stage_slot_r;
  logic       mic_stage_r, bank_r;
  logic       anonce_ok_r, snonce_ok_r, mic_ok_r;

  logic [7:0]    nonce_q_r, bank_q_r;
  logic [1:0]    region_q_r;
  logic          hit_q_r;
  logic          hit;
  logic [1:0]    rd_slot;
  logic [6:0]    wr_addr, rd_addr;
  logic [CW+7:0] ofs_w, slen_w;

  assign ofs_w   = {{CW{1'b0}}, rd_offset};
  assign slen_w  = {8'd0, saved_len};
  assign rd_slot = (rd_region == REGION_ANONCE) ? anonce_slot_r : snonce_slot_r;

  // Nonce and MIC bytes sit at disjoint frame offsets, so one write port serves both.
  assign wr_addr = cap.nonce_we ? {stage_slot_r, cap.nonce_idx}
                                : {MIC_SLOT, mic_stage_r, cap.mic_idx};
  assign rd_addr = (rd_region == REGION_MIC) ? {MIC_SLOT, ~mic_stage_r, rd_offset[3:0]}
                                             : {rd_slot, rd_offset[4:0]};

  always_comb begin
    unique case (rd_region)
      REGION_ANONCE: hit = anonce_ok_r && (rd_offset < 8'(NONCE_LEN));
      REGION_SNONCE: hit = snonce_ok_r && (rd_offset < 8'(NONCE_LEN));
      REGION_MIC:    hit = mic_ok_r && (rd_offset < 8'(MIC_LEN));
      default:       hit = (ofs_w < slen_w) && (ofs_w < (CW+8)'(FRAME_MAX));
    endcase
  end

  always_ff @(posedge clk) begin
    if (cap.nonce_we || cap.mic_we) begin
      nonce_mem[wr_addr] <= cap.data;
    end
    if (cap.bank_we) begin
      bank_mem[{~bank_r, bank_pos}] <= cap.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      nonce_q_r  <= nonce_mem[rd_addr];
      bank_q_r   <= bank_mem[{bank_r, ofs_w[PW-1:0]}];
      region_q_r <= rd_region;
      hit_q_r    <= hit;
    end
  end

  // Commits swap pointers instead of copying data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anonce_slot_r <= 2'd0;
      snonce_slot_r <= 2'd1;
      stage_slot_r  <= 2'd2;
      mic_stage_r   <= 1'b0;
      bank_r        <= 1'b0;
      anonce_ok_r   <= 1'b0;
      snonce_ok_r   <= 1'b0;
      mic_ok_r      <= 1'b0;
    end else begin
      if (commit.anonce) begin
        anonce_slot_r <= stage_slot_r;
        stage_slot_r  <= anonce_slot_r;
        anonce_ok_r   <= 1'b1;
      end else if (commit.snonce_mic) begin
        snonce_slot_r <= stage_slot_r;
        stage_slot_r  <= snonce_slot_r;
        mic_stage_r   <= ~mic_stage_r;
        snonce_ok_r   <= 1'b1;
        mic_ok_r      <= 1'b1;
      end
      if (commit.frame) begin
        bank_r <= ~bank_r;
      end
    end
  end

  always_comb begin
    rd_data = 8'd0;
    if (hit_q_r) begin
      rd_data = (region_q_r == REGION_FRAME) ? bank_q_r : nonce_q_r;
    end
  end

endmodule

@@ rtl/eapol_handshake_tracker_core.sv @@
// EAPOL-Key four-way handshake tracker, top level; depends on eht_pkg, eht_frame_ctl,
// eht_store and eapol_handshake_tracker_core_macros.svh.
// Path: a result passes through the memory read stage, then the output register.
// Throughput: 1 beat per cycle while in_stall is low; each beat is one write or one read on the capture memories.
// Stall: no result for frame beats but the last; input stalls only with both stages full.
// Reset (rst_n low, synchronous) clears counters, learned addresses, progress and pointers.
`include "eapol_handshake_tracker_core_macros.svh"

module eapol_handshake_tracker_core import eht_pkg::*; #(
  parameter int unsigned FRAME_MAX = FRAME_MAX_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_item,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_item
);

  localparam int unsigned CW = $clog2(FRAME_MAX + 2);
  localparam int unsigned PW = $clog2(FRAME_MAX);

  // Handshake on the input side: a beat is taken whenever the read stage can move on.
  logic accept, byte_en, rd_en, has_result;

  // Stage 1: memory read in flight, status snapshot held alongside.
  logic s1_valid_r;
  out_t s1_res_r;
  out_t s1_out;
  logic s1_adv;

  // Stage 2: output register.
  logic out_valid_r;
  out_t out_r;

  cap_t          cap;
  commit_t       commit;
  status_t       status;
  logic [PW-1:0] bank_pos;
  logic [CW-1:0] saved_len;
  logic [2:0]    msg_code;
  logic [7:0]    rd_data;

  assign s1_adv     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall   = s1_valid_r && out_valid_r && out_stall;
  assign accept     = in_valid && !in_stall;
  assign byte_en    = accept && (in_item.req_type == REQ_FRAME);
  assign rd_en      = accept && (in_item.req_type == REQ_READ);
  // Reads always answer; frame beats answer only on the last byte.
  assign has_result = (in_item.req_type == REQ_READ) || in_item.last_byte;

  eht_frame_ctl #(.FRAME_MAX(FRAME_MAX)) u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_en),
    .data_byte (in_item.data_byte),
    .last_byte (in_item.last_byte),
    .src_addr  (in_item.src_addr),
    .dst_addr  (in_item.dst_addr),
    .cap       (cap),
    .bank_pos  (bank_pos),
    .commit    (commit),
    .saved_len (saved_len),
    .msg_code  (msg_code),
    .status    (status)
  );

  eht_store #(.FRAME_MAX(FRAME_MAX)) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap       (cap),
    .bank_pos  (bank_pos),
    .commit    (commit),
    .rd_en     (rd_en),
    .rd_region (in_item.read_region),
    .rd_offset (in_item.read_offset),
    .saved_len (saved_len),
    .rd_data   (rd_data)
  );

  // Status snapshot: post-update for a verdict, unchanged state for a read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || s1_adv) begin
      s1_valid_r <= accept && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r.result_kind        <= in_item.req_type;
      s1_res_r.msg_code           <= msg_code;
      s1_res_r.progress_mask      <= status.seen;
      s1_res_r.handshake_complete <= status.done;
      s1_res_r.ap_addr            <= status.ap;
      s1_res_r.client_addr        <= status.client;
      s1_res_r.stored_len         <= status.stored_len;
      s1_res_r.read_data          <= 8'd0;
    end
  end

  // Read data from the store is stable while stage 1 holds: no new read starts then.
  always_comb begin
    s1_out = s1_res_r;
    if (s1_res_r.result_kind == REQ_READ) begin
      s1_out.read_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= s1_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `EHT_ASSERT_IMPL(a_stall_needs_full, in_stall, s1_valid_r && out_valid_r)
  `EHT_ASSERT_IMPL(a_read_no_msg, out_valid_r && out_r.result_kind, out_r.msg_code == MSG_NONE)
  `EHT_ASSERT_IMPL(a_done_all_seen, out_valid_r && out_r.handshake_complete, out_r.progress_mask == 4'hF)
  `EHT_ASSERT_NEXT(a_commit_exclusive, commit.anonce, !commit.snonce_mic || !$past(commit.snonce_mic))
  `EHT_ASSERT_IMPL(a_frame_commit_m2, commit.frame, commit.snonce_mic && (msg_code == MSG_2))

endmodule
